[rtl/int_literal_parser_top_defines.svh]
// Assertion macros used by the top level of the integer literal parser.
`ifndef INT_LITERAL_PARSER_TOP_DEFINES_SVH
`define INT_LITERAL_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ILP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ILP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ilp_pkg.sv]
// Types, codes and constants of the integer literal parser.
package ilp_pkg;

	typedef enum logic [1:0] {
		PH_START,
		PH_PREFIX,
		PH_DIGITS,
		PH_SUFFIX
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_HEX,
		BASE_BIN,
		BASE_OCT
	} base_t;

	localparam logic [2:0] TY_I8  = 3'd0;
	localparam logic [2:0] TY_I16 = 3'd1;
	localparam logic [2:0] TY_I32 = 3'd2;
	localparam logic [2:0] TY_I64 = 3'd3;
	localparam logic [2:0] TY_U8  = 3'd4;
	localparam logic [2:0] TY_U16 = 3'd5;
	localparam logic [2:0] TY_U32 = 3'd6;
	localparam logic [2:0] TY_U64 = 3'd7;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_X     = 8'h78;

	localparam logic [63:0] MAX_I32 = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] POW2_31 = 64'h0000_0000_8000_0000;
	localparam logic [63:0] MAX_U32 = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] MAX_I64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX_U64 = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [63:0] TYPE_MAX [8] = '{
		64'd127, 64'd32767, MAX_I32, MAX_I64,
		64'd255, 64'd65535, MAX_U32, MAX_U64
	};

	localparam int SFX_DEPTH = 3;

	// Running state of the literal being parsed.
	typedef struct packed {
		phase_t     phase;
		base_t      base;
		logic [63:0] accum;
		logic       digit_seen;
		logic       neg;
		logic       ovf;
		logic       zero_pending;
		logic [2:0] sfx_count;
	} lit_state_t;

	// Everything the result stage needs once the literal has ended.
	typedef struct packed {
		base_t      base;
		logic [63:0] accum;
		logic       digit_seen;
		logic       neg;
		logic       ovf;
		logic [2:0] sfx_count;
		logic [SFX_DEPTH-1:0][7:0] sfx_chars;
	} lit_final_t;

	localparam lit_state_t STATE_RESET = '{
		phase: PH_START,
		base: BASE_DEC,
		accum: 64'd0,
		digit_seen: 1'b0,
		neg: 1'b0,
		ovf: 1'b0,
		zero_pending: 1'b0,
		sfx_count: 3'd0
	};

	// Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic digit_in_base(input logic [3:0] v, input base_t b);
		logic ok;
		unique case (b)
			BASE_DEC: ok = (v < 4'd10);
			BASE_HEX: ok = 1'b1;
			BASE_BIN: ok = (v < 4'd2);
			BASE_OCT: ok = (v < 4'd8);
			default:  ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

[rtl/ilp_step.sv]
// Per-character update of the literal parse state.
module ilp_step import ilp_pkg::*; (
	input  lit_state_t                cur,
	input  logic [SFX_DEPTH-1:0][7:0] sfx_cur,
	input  logic [7:0]                char_code,
	input  logic                      is_last,
	output lit_state_t                nxt,
	output logic [SFX_DEPTH-1:0][7:0] sfx_nxt
);

	typedef struct packed {
		phase_t phase;
		logic   minus_taken;
		logic   in_prefix;
		logic   prefix_pick;
		logic   zp_set;
		logic   zero_digit;
		logic   digit_take;
		logic   in_suffix;
	} step_ctl_t;

	step_ctl_t  ctl;
	logic [4:0] hd;
	logic       is_digit;
	logic       is_pfx_char;
	logic [67:0] wide;
	logic [67:0] acc_x;
	logic       ovf_now;
	base_t      pfx_base;

	assign hd       = hex_digit(char_code);
	assign is_digit = hd[4] && digit_in_base(hd[3:0], cur.base);
	assign is_pfx_char = (char_code == CH_X) || (char_code == CH_B) || (char_code == CH_O);

	// Phase sequencing: which part of the literal this character belongs to.
	always_comb begin
		phase_t ph_pre;
		phase_t ph_mid;
		logic   in_digits;
		ph_pre = (cur.phase == PH_START) ? PH_PREFIX : cur.phase;
		ctl.minus_taken = (cur.phase == PH_START) && (char_code == CH_MINUS);
		ctl.in_prefix   = !ctl.minus_taken && (ph_pre == PH_PREFIX);
		ctl.prefix_pick = ctl.in_prefix && cur.zero_pending && is_pfx_char;
		ctl.zp_set      = ctl.in_prefix && !cur.zero_pending && (char_code == CH_ZERO)
			&& !is_last;
		ctl.zero_digit  = ctl.in_prefix && cur.zero_pending && !is_pfx_char;
		ph_mid = (ctl.in_prefix && !ctl.zp_set) ? PH_DIGITS : ph_pre;
		in_digits = !ctl.minus_taken && !ctl.prefix_pick && (ph_mid == PH_DIGITS)
			&& (char_code != CH_UNDER);
		ctl.digit_take = in_digits && is_digit;
		ctl.in_suffix  = (in_digits && !is_digit) ||
			(!ctl.minus_taken && (ph_mid == PH_SUFFIX));
		ctl.phase = (in_digits && !is_digit) ? PH_SUFFIX : ph_mid;
	end

	always_comb begin
		unique case (char_code)
			CH_X:    pfx_base = BASE_HEX;
			CH_B:    pfx_base = BASE_BIN;
			default: pfx_base = BASE_OCT;
		endcase
	end

	// accum * base + digit, kept four bits wider to see the carry out.
	assign acc_x = {4'd0, cur.accum};
	always_comb begin
		unique case (cur.base)
			BASE_DEC: wide = (acc_x << 3) + (acc_x << 1) + {64'd0, hd[3:0]};
			BASE_HEX: wide = (acc_x << 4) | {64'd0, hd[3:0]};
			BASE_BIN: wide = (acc_x << 1) | {64'd0, hd[3:0]};
			default:  wide = (acc_x << 3) | {64'd0, hd[3:0]};
		endcase
	end

	assign ovf_now = (wide[67:64] != 4'd0) || (cur.neg && wide[63]);

	always_comb begin
		nxt = cur;
		sfx_nxt = sfx_cur;
		nxt.phase = ctl.phase;
		if (ctl.minus_taken) begin
			nxt.neg = 1'b1;
		end
		if (ctl.prefix_pick) begin
			nxt.base = pfx_base;
		end
		if (ctl.zp_set) begin
			nxt.zero_pending = 1'b1;
		end else if (ctl.in_prefix && cur.zero_pending) begin
			nxt.zero_pending = 1'b0;
		end
		// A held zero that is no prefix is a digit on a zero value: only the flag moves.
		if (ctl.zero_digit) begin
			nxt.digit_seen = 1'b1;
		end
		if (ctl.digit_take) begin
			nxt.accum = wide[63:0];
			nxt.digit_seen = 1'b1;
			nxt.ovf = cur.ovf | ovf_now;
		end
		if (ctl.in_suffix) begin
			if (cur.sfx_count < 3'(SFX_DEPTH)) begin
				sfx_nxt[cur.sfx_count[1:0]] = char_code;
			end
			if (cur.sfx_count < 3'(SFX_DEPTH + 1)) begin
				nxt.sfx_count = cur.sfx_count + 3'd1;
			end
		end
	end

endmodule

[rtl/ilp_type.sv]
// Suffix match, default type choice and range check of a finished literal.
module ilp_type import ilp_pkg::*; (
	input  lit_final_t fin,
	output logic [2:0] type_code,
	output logic       bad_suffix,
	output logic       too_large
);

	logic       sfx_valid;
	logic [2:0] sfx_type;
	logic       sgn_u;
	logic       sgn_ok;
	logic [7:0] gt_max;
	logic       le_i32;
	logic       le_p31;
	logic       le_u32;
	logic       le_i64;

	assign sgn_u  = (fin.sfx_chars[0] == CH_U);
	assign sgn_ok = sgn_u || (fin.sfx_chars[0] == CH_I);

	always_comb begin
		sfx_valid  = 1'b0;
		bad_suffix = 1'b0;
		sfx_type   = TY_I8;
		case (fin.sfx_count)
			3'd0: begin
			end
			3'd1: begin
				sfx_valid  = sgn_u;
				bad_suffix = !sgn_u;
				sfx_type   = TY_U32;
			end
			3'd2: begin
				sfx_valid  = sgn_ok && (fin.sfx_chars[1] == CH_EIGHT);
				bad_suffix = !sfx_valid;
				sfx_type   = sgn_u ? TY_U8 : TY_I8;
			end
			3'd3: begin
				if (fin.sfx_chars[1] == CH_ONE && fin.sfx_chars[2] == CH_SIX) begin
					sfx_type = sgn_u ? TY_U16 : TY_I16;
					sfx_valid = sgn_ok;
				end else if (fin.sfx_chars[1] == CH_THREE && fin.sfx_chars[2] == CH_TWO) begin
					sfx_type = sgn_u ? TY_U32 : TY_I32;
					sfx_valid = sgn_ok;
				end else if (fin.sfx_chars[1] == CH_SIX && fin.sfx_chars[2] == CH_FOUR) begin
					sfx_type = sgn_u ? TY_U64 : TY_I64;
					sfx_valid = sgn_ok;
				end
				bad_suffix = !sfx_valid;
			end
			default: begin
				bad_suffix = 1'b1;
			end
		endcase
	end

	assign le_i32 = (fin.accum <= MAX_I32);
	assign le_p31 = (fin.accum <= POW2_31);
	assign le_u32 = (fin.accum <= MAX_U32);
	assign le_i64 = (fin.accum <= MAX_I64);

	always_comb begin
		if (sfx_valid) begin
			type_code = sfx_type;
		end else if (fin.neg) begin
			type_code = le_p31 ? TY_I32 : TY_I64;
		end else if (fin.base == BASE_DEC) begin
			type_code = le_i32 ? TY_I32 : TY_I64;
		end else if (le_i32) begin
			type_code = TY_I32;
		end else if (le_u32) begin
			type_code = TY_U32;
		end else if (le_i64) begin
			type_code = TY_I64;
		end else begin
			type_code = TY_U64;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			gt_max[i] = (fin.accum > TYPE_MAX[i]);
		end
	end

	assign too_large = gt_max[type_code];

endmodule

[rtl/int_literal_parser_top.sv]
// Top level of the integer literal parser: input register, parse state, result stages.
//
//  channel | direction | payload                                  | handshake
//  --------+-----------+------------------------------------------+--------------------
//  in      | request in| char_code, is_last                       | in_valid / in_stall
//  out     | result out| magnitude, is_negative, type_code,       | out_valid / out_stall
//          |           | overflow_seen, no_digits, bad_suffix,    |
//          |           | too_large                                |
//
// One character is taken every cycle while in_stall is low; the limit is the per-character
// multiply-add and carry check that updates the running value. A result passes from the
// input register through the result stage into the output register. Reset returns the
// parser to the start of a literal and empties every stage. Characters that end no
// literal keep flowing while a result is stalled; a final character waits only when
// both result stages are full and the result is stalled.
`include "int_literal_parser_top_defines.svh"

module int_literal_parser_top import ilp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] magnitude,
	output logic        is_negative,
	output logic [2:0]  type_code,
	output logic        overflow_seen,
	output logic        no_digits,
	output logic        bad_suffix,
	output logic        too_large
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	lit_state_t                state_q;
	lit_state_t                state_nxt;
	logic [SFX_DEPTH-1:0][7:0] sfx_q;
	logic [SFX_DEPTH-1:0][7:0] sfx_nxt;

	logic       valid_s2;
	lit_final_t fin_s2;

	logic [2:0] type_code_d;
	logic       bad_suffix_d;
	logic       too_large_d;

	logic        out_valid_q;
	logic [63:0] magnitude_q;
	logic        is_negative_q;
	logic [2:0]  type_code_q;
	logic        overflow_seen_q;
	logic        no_digits_q;
	logic        bad_suffix_q;
	logic        too_large_q;

	logic out_free;
	logic s2_move;
	logic s2_free;
	logic consume_s1;

	logic last_take;
	logic s2_hold;
	logic nodig_out;
	logic at_start;
	logic start_clean;

	assign out_free   = !out_valid_q || !out_stall;
	assign s2_move    = valid_s2 && out_free;
	assign s2_free    = !valid_s2 || s2_move;
	assign consume_s1 = valid_s1 && (!last_s1 || s2_free);
	assign in_stall   = valid_s1 && !consume_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	ilp_step u_step (
		.cur       (state_q),
		.sfx_cur   (sfx_q),
		.char_code (char_s1),
		.is_last   (last_s1),
		.nxt       (state_nxt),
		.sfx_nxt   (sfx_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (consume_s1) begin
			state_q <= last_s1 ? STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1) begin
			sfx_q <= sfx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && last_s1) begin
			fin_s2.base       <= state_nxt.base;
			fin_s2.accum      <= state_nxt.accum;
			fin_s2.digit_seen <= state_nxt.digit_seen;
			fin_s2.neg        <= state_nxt.neg;
			fin_s2.ovf        <= state_nxt.ovf;
			fin_s2.sfx_count  <= state_nxt.sfx_count;
			fin_s2.sfx_chars  <= sfx_nxt;
		end
	end

	ilp_type u_type (
		.fin        (fin_s2),
		.type_code  (type_code_d),
		.bad_suffix (bad_suffix_d),
		.too_large  (too_large_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			magnitude_q     <= fin_s2.accum;
			is_negative_q   <= fin_s2.neg;
			type_code_q     <= type_code_d;
			overflow_seen_q <= fin_s2.ovf;
			no_digits_q     <= !fin_s2.digit_seen;
			bad_suffix_q    <= bad_suffix_d;
			too_large_q     <= too_large_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign magnitude     = magnitude_q;
	assign is_negative   = is_negative_q;
	assign type_code     = type_code_q;
	assign overflow_seen = overflow_seen_q;
	assign no_digits     = no_digits_q;
	assign bad_suffix    = bad_suffix_q;
	assign too_large     = too_large_q;

	assign last_take   = consume_s1 && last_s1;
	assign s2_hold     = valid_s2 && !s2_move;
	assign nodig_out   = out_valid_q && no_digits_q;
	assign at_start    = (state_q.phase == PH_START);
	assign start_clean = (state_q.accum == 64'd0) && !state_q.digit_seen && !state_q.ovf
		&& !state_q.neg && (state_q.sfx_count == 3'd0);

	// A literal without digits never builds a value.
	`ILP_ASSERT_NOW(a_nodigit_zero, nodig_out, magnitude_q == 64'd0, "digitless value not zero")
	// At the start of a literal nothing of the previous one may linger.
	`ILP_ASSERT_NOW(a_start_clean, at_start, start_clean, "stale state at literal start")
	// The final character hands the literal to the result stage and rearms the parser.
	`ILP_ASSERT_NEXT(a_last_rearm, last_take, at_start && valid_s2, "literal not closed")
	// A finished literal that cannot move on keeps its value.
	`ILP_ASSERT_NEXT(a_s2_hold, s2_hold, valid_s2 && $stable(fin_s2), "held literal changed")

endmodule
